// File: rtl/pnra_pkg.sv
package pnra_pkg;

    localparam int unsigned MAX_NODES      = 1024;
    localparam int unsigned MAX_DIRECTIONS = 6;
    localparam int unsigned STORE_DEPTH    = MAX_NODES * MAX_DIRECTIONS;
    localparam int unsigned ADDR_W         = $clog2(STORE_DEPTH);
    localparam int unsigned DIR_W          = $clog2(MAX_DIRECTIONS);

    // fixed field widths
    localparam int unsigned NODE_W  = 10;
    localparam int unsigned DIRF_W  = 3;
    localparam int unsigned NB_W    = 11;
    localparam int unsigned PERM_W  = 32;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned VALUE_W = 40;
    localparam int unsigned SUM_W   = PERM_W + 1;
    localparam int unsigned DIAG_W  = SUM_W + 3;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 32;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROCESS = 1'b1;

    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] DIM_3  = 2'd3;

    localparam logic [CIDX_W-1:0] REG_FLOW_AXIS     = 2'd0;
    localparam logic [CIDX_W-1:0] REG_DIMENSION     = 2'd1;
    localparam logic [CIDX_W-1:0] REG_DOMAIN_EXTENT = 2'd2;

    localparam logic [VALUE_W-1:0] UNIT_VALUE = VALUE_W'(131072);

    typedef struct packed {
        logic [1:0]         flow_axis;
        logic [1:0]         dimension;
        logic [COORD_W-1:0] domain_extent;
    } cfg_t;

    typedef struct packed {
        logic [NODE_W-1:0]         row;
        logic [NODE_W-1:0]         column;
        logic signed [VALUE_W-1:0] value;
        logic                      rhs_increment;
        logic                      error;
        logic                      last;
    } res_t;

    // direction paired with d on the far side of the throat
    function automatic logic [DIRF_W-1:0] opposite_dir(input logic [DIRF_W-1:0] d);
        logic [DIRF_W-1:0] o;
        case (d)
            3'd0:    o = 3'd2;
            3'd1:    o = 3'd3;
            3'd2:    o = 3'd0;
            3'd3:    o = 3'd1;
            3'd4:    o = 3'd5;
            3'd5:    o = 3'd4;
            default: o = 3'd0;
        endcase
        return o;
    endfunction

endpackage

// File: rtl/pnra_ram.sv
module pnra_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pnra_seq.sv
module pnra_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pnra_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic [pnra_pkg::NODE_W-1:0]  node,
    input  logic [pnra_pkg::DIRF_W-1:0]  direction,
    input  logic [pnra_pkg::NB_W-1:0]    neighbor,
    input  logic [pnra_pkg::PERM_W-1:0]  permeability,
    input  logic                         is_free,
    input  logic [pnra_pkg::COORD_W-1:0] coordinate,
    output logic                         res_valid,
    output pnra_pkg::res_t               res,
    input  logic                         res_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_OWN,
        S_GET_OWN,
        S_GET_REV,
        S_PUSH
    } state_t;

    state_t state_reg, state_next;

    logic [pnra_pkg::NODE_W-1:0] row_reg, row_next;
    logic [pnra_pkg::ADDR_W-1:0] base_reg, base_next;
    logic [pnra_pkg::DIR_W-1:0]  d_reg, d_next;
    logic [pnra_pkg::DIR_W-1:0]  dir_last_reg, dir_last_next;
    logic [pnra_pkg::DIAG_W-1:0] diag_reg, diag_next;
    logic [pnra_pkg::PERM_W-1:0] kown_reg, kown_next;
    logic [pnra_pkg::NODE_W-1:0] nb_reg, nb_next;
    pnra_pkg::res_t              res_reg, res_next;

    logic                        accept;
    logic                        load_we;
    logic [pnra_pkg::ADDR_W-1:0] load_addr;
    logic [pnra_pkg::ADDR_W-1:0] own_addr;
    logic [pnra_pkg::ADDR_W-1:0] rev_addr;
    logic [pnra_pkg::ADDR_W-1:0] perm_raddr;
    logic [pnra_pkg::NB_W-1:0]   nb_rdata;
    logic [pnra_pkg::PERM_W-1:0] perm_rdata;
    logic                        nb_present;
    logic                        err_mode;
    logic [pnra_pkg::SUM_W-1:0]  sum;
    int unsigned                 ndirs;
    pnra_pkg::res_t              diag_res;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign res_valid = (state_reg == S_PUSH);
    assign res       = res_reg;

    assign load_we = accept && (cmd == pnra_pkg::CMD_LOAD)
                     && (32'(node) < pnra_pkg::MAX_NODES)
                     && (32'(direction) < pnra_pkg::MAX_DIRECTIONS);
    assign load_addr = pnra_pkg::ADDR_W'(node) * pnra_pkg::ADDR_W'(pnra_pkg::MAX_DIRECTIONS)
                       + pnra_pkg::ADDR_W'(direction);

    assign own_addr = base_reg + pnra_pkg::ADDR_W'(d_reg);
    assign rev_addr = pnra_pkg::ADDR_W'(nb_rdata[pnra_pkg::NODE_W-1:0])
                      * pnra_pkg::ADDR_W'(pnra_pkg::MAX_DIRECTIONS)
                      + pnra_pkg::ADDR_W'(pnra_pkg::opposite_dir(pnra_pkg::DIRF_W'(d_reg)));
    assign perm_raddr = (state_reg == S_GET_OWN) ? rev_addr : own_addr;

    // negative or out-of-range index means no neighbor
    assign nb_present = !nb_rdata[pnra_pkg::NB_W-1]
                        && (32'(nb_rdata[pnra_pkg::NODE_W-1:0]) < pnra_pkg::MAX_NODES);

    assign err_mode = (cfg.flow_axis >= pnra_pkg::AXIS_Z) && (cfg.dimension != pnra_pkg::DIM_3);
    assign sum      = pnra_pkg::SUM_W'(kown_reg) + pnra_pkg::SUM_W'(perm_rdata);

    pnra_ram #(
        .WIDTH (pnra_pkg::NB_W),
        .DEPTH (pnra_pkg::STORE_DEPTH)
    ) u_nb_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (neighbor),
        .raddr (own_addr),
        .rdata (nb_rdata)
    );

    pnra_ram #(
        .WIDTH (pnra_pkg::PERM_W),
        .DEPTH (pnra_pkg::STORE_DEPTH)
    ) u_perm_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (permeability),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    always_comb
    begin
        ndirs = (cfg.dimension == pnra_pkg::DIM_3) ? 6 : 4;
        if (ndirs > pnra_pkg::MAX_DIRECTIONS)
        begin
            ndirs = pnra_pkg::MAX_DIRECTIONS;
        end

        diag_res.row           = row_reg;
        diag_res.column        = row_reg;
        diag_res.value         = pnra_pkg::VALUE_W'(diag_reg);
        diag_res.rhs_increment = 1'b0;
        diag_res.error         = 1'b0;
        diag_res.last          = 1'b1;

        state_next    = state_reg;
        row_next      = row_reg;
        base_next     = base_reg;
        d_next        = d_reg;
        dir_last_next = dir_last_reg;
        diag_next     = diag_reg;
        kown_next     = kown_reg;
        nb_next       = nb_reg;
        res_next      = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == pnra_pkg::CMD_PROCESS))
                begin
                    row_next      = node;
                    base_next     = pnra_pkg::ADDR_W'(node)
                                    * pnra_pkg::ADDR_W'(pnra_pkg::MAX_DIRECTIONS);
                    d_next        = '0;
                    dir_last_next = pnra_pkg::DIR_W'(ndirs - 1);
                    diag_next     = '0;
                    res_next.row           = node;
                    res_next.column        = node;
                    res_next.value         = pnra_pkg::UNIT_VALUE;
                    res_next.rhs_increment = 1'b0;
                    res_next.error         = 1'b0;
                    res_next.last          = 1'b1;
                    if (err_mode)
                    begin
                        res_next.column = '0;
                        res_next.value  = '0;
                        res_next.error  = 1'b1;
                        state_next      = S_PUSH;
                    end
                    else if (!is_free || (32'(node) >= pnra_pkg::MAX_NODES))
                    begin
                        state_next = S_IDLE;
                    end
                    else if (coordinate == '0)
                    begin
                        res_next.rhs_increment = 1'b1;
                        state_next             = S_PUSH;
                    end
                    else if (coordinate >= cfg.domain_extent)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_RD_OWN;
                    end
                end
            end

            S_RD_OWN:
            begin
                state_next = S_GET_OWN;
            end

            S_GET_OWN:
            begin
                kown_next = perm_rdata;
                nb_next   = nb_rdata[pnra_pkg::NODE_W-1:0];
                if (nb_present)
                begin
                    state_next = S_GET_REV;
                end
                else if (d_reg == dir_last_reg)
                begin
                    res_next   = diag_res;
                    state_next = S_PUSH;
                end
                else
                begin
                    d_next     = d_reg + pnra_pkg::DIR_W'(1);
                    state_next = S_RD_OWN;
                end
            end

            S_GET_REV:
            begin
                res_next.row           = row_reg;
                res_next.column        = nb_reg;
                res_next.value         = '0 - pnra_pkg::VALUE_W'(sum);
                res_next.rhs_increment = 1'b0;
                res_next.error         = 1'b0;
                res_next.last          = 1'b0;
                diag_next              = diag_reg + pnra_pkg::DIAG_W'(sum);
                state_next             = S_PUSH;
            end

            S_PUSH:
            begin
                if (res_ready)
                begin
                    if (res_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (d_reg == dir_last_reg)
                    begin
                        res_next = diag_res;
                    end
                    else
                    begin
                        d_next     = d_reg + pnra_pkg::DIR_W'(1);
                        state_next = S_RD_OWN;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        base_reg     <= base_next;
        d_reg        <= d_next;
        dir_last_reg <= dir_last_next;
        diag_reg     <= diag_next;
        kown_reg     <= kown_next;
        nb_reg       <= nb_next;
        res_reg      <= res_next;
    end

endmodule

// File: rtl/pore_network_matrix_row_assembly.sv
// Channel   Signals                                              Direction
// cfg       cfg_we, cfg_index, cfg_data                          write only
// in        in_valid/in_stall, cmd node direction neighbor       request in
//           permeability is_free coordinate
// out       out_valid/out_stall, row column value rhs_increment  request out
//           error last
//
// Load requests and fixed nodes are taken without leaving idle; unit and error
// rows go through the push step. An interior node reads, per direction, its own
// entry and then the reverse entry through the single read port of the
// permeability memory, pushes one entry per present link, then the diagonal.
// Reset clears control state only; the neighbor and permeability memories
// hold garbage until loaded, with no clearing pass.
// out_stall holds the output register; the sequencer waits at its push step.
module pore_network_matrix_row_assembly (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pnra_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [pnra_pkg::CDATA_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [pnra_pkg::NODE_W-1:0]   node,
    input  logic [pnra_pkg::DIRF_W-1:0]   direction,
    input  logic signed [pnra_pkg::NB_W-1:0] neighbor,
    input  logic [pnra_pkg::PERM_W-1:0]   permeability,
    input  logic                          is_free,
    input  logic [pnra_pkg::COORD_W-1:0]  coordinate,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pnra_pkg::NODE_W-1:0]   row,
    output logic [pnra_pkg::NODE_W-1:0]   column,
    output logic signed [pnra_pkg::VALUE_W-1:0] value,
    output logic                          rhs_increment,
    output logic                          error,
    output logic                          last
);

    pnra_pkg::cfg_t cfg_reg;
    pnra_pkg::res_t res;
    pnra_pkg::res_t out_reg;
    logic           res_valid;
    logic           res_ready;
    logic           out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flow_axis     <= 2'd0;
            cfg_reg.dimension     <= pnra_pkg::DIM_3;
            cfg_reg.domain_extent <= pnra_pkg::COORD_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pnra_pkg::REG_FLOW_AXIS:     cfg_reg.flow_axis     <= cfg_data[1:0];
                pnra_pkg::REG_DIMENSION:     cfg_reg.dimension     <= cfg_data[1:0];
                pnra_pkg::REG_DOMAIN_EXTENT: cfg_reg.domain_extent <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pnra_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .node         (node),
        .direction    (direction),
        .neighbor     (neighbor),
        .permeability (permeability),
        .is_free      (is_free),
        .coordinate   (coordinate),
        .res_valid    (res_valid),
        .res          (res),
        .res_ready    (res_ready)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign row           = out_reg.row;
    assign column        = out_reg.column;
    assign value         = out_reg.value;
    assign rhs_increment = out_reg.rhs_increment;
    assign error         = out_reg.error;
    assign last          = out_reg.last;

endmodule

// File: sim/pore_network_matrix_row_assembly_tb.sv
`timescale 1ns / 100ps

module pore_network_matrix_row_assembly_tb;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES   = 500;

    localparam logic [pnra_pkg::CIDX_W-1:0] REG_UNUSED = 2'd3;

    // reverse slot of each direction, three bits per entry, direction 0 lowest
    localparam logic [17:0] FAR_SIDE = {3'd4, 3'd5, 3'd1, 3'd0, 3'd3, 3'd2};

    localparam logic signed [pnra_pkg::NB_W-1:0] NO_NEIGHBOR = -11'sd1;

    typedef struct {
        logic                               cmd;
        logic [pnra_pkg::NODE_W-1:0]        node;
        logic [pnra_pkg::DIRF_W-1:0]        dir;
        logic signed [pnra_pkg::NB_W-1:0]   nbr;
        logic [pnra_pkg::PERM_W-1:0]        perm;
        logic                               free;
        logic [pnra_pkg::COORD_W-1:0]       coord;
    } request_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                                 cfg_we = 1'b0;
    logic [pnra_pkg::CIDX_W-1:0]          cfg_index = '0;
    logic [pnra_pkg::CDATA_W-1:0]         cfg_data = '0;

    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic                                 cmd = 1'b0;
    logic [pnra_pkg::NODE_W-1:0]          node = '0;
    logic [pnra_pkg::DIRF_W-1:0]          direction = '0;
    logic signed [pnra_pkg::NB_W-1:0]     neighbor = '0;
    logic [pnra_pkg::PERM_W-1:0]          permeability = '0;
    logic                                 is_free = 1'b0;
    logic [pnra_pkg::COORD_W-1:0]         coordinate = '0;

    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [pnra_pkg::NODE_W-1:0]          row;
    logic [pnra_pkg::NODE_W-1:0]          column;
    logic signed [pnra_pkg::VALUE_W-1:0]  value;
    logic                                 rhs_increment;
    logic                                 error;
    logic                                 last;

    pore_network_matrix_row_assembly dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .node          (node),
        .direction     (direction),
        .neighbor      (neighbor),
        .permeability  (permeability),
        .is_free       (is_free),
        .coordinate    (coordinate),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row           (row),
        .column        (column),
        .value         (value),
        .rhs_increment (rhs_increment),
        .error         (error),
        .last          (last)
    );

    // predictor state
    logic signed [pnra_pkg::NB_W-1:0] nbr_mem  [0:pnra_pkg::STORE_DEPTH-1];
    logic [pnra_pkg::PERM_W-1:0]      perm_mem [0:pnra_pkg::STORE_DEPTH-1];
    logic [1:0]                       axis_r   = 2'd0;
    logic [1:0]                       dim_r    = 2'd3;
    logic [pnra_pkg::COORD_W-1:0]     extent_r = 32'd65536;

    // stimulus side bookkeeping: which store entries have been loaded so far
    bit                               loaded_gen [0:pnra_pkg::STORE_DEPTH-1];
    logic [pnra_pkg::NODE_W-1:0]      ready_nodes[$];

    request_t                         pending_requests[$];
    pnra_pkg::res_t                   expected_entries[$];

    request_t                         cur_req;
    request_t                         next_req;
    pnra_pkg::res_t                   want;

    int unsigned cycle;
    int unsigned queued_count;
    int unsigned accepted_count;
    int unsigned entries_checked;
    int unsigned interior_rows;
    int unsigned error_rows;
    int unsigned mismatches;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned hold_token;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned rx_mode;
    logic [5:0]  rx_tick;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        cycle <= cycle + 1;

    initial
    begin
        while (cycle < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        mismatches++;
        $display("mismatch, cycle %0d: %s got %h expected %h", cycle, what, got, exp_val);
    endtask

    function automatic pnra_pkg::res_t make_entry(input logic [pnra_pkg::NODE_W-1:0] r,
                                                  input logic [pnra_pkg::NODE_W-1:0] c,
                                                  input logic [pnra_pkg::VALUE_W-1:0] v,
                                                  input logic rhs,
                                                  input logic err, input logic lst);
        pnra_pkg::res_t e;
        e.row           = r;
        e.column        = c;
        e.value         = v;
        e.rhs_increment = rhs;
        e.error         = err;
        e.last          = lst;
        return e;
    endfunction

    task automatic expect_entry(input pnra_pkg::res_t e);
        expected_entries = {expected_entries, e};
    endtask

    // Works out the row entries for one accepted request, in emission order.
    task automatic assemble_row(input request_t r);
        int unsigned base;
        int unsigned ndirs;
        int unsigned far_idx;
        logic signed [pnra_pkg::NB_W-1:0] nb;
        logic [pnra_pkg::SUM_W-1:0]       sum;
        logic [pnra_pkg::DIAG_W-1:0]      diag;
        base = r.node * pnra_pkg::MAX_DIRECTIONS;
        if (r.cmd == pnra_pkg::CMD_LOAD)
        begin
            if (r.dir < pnra_pkg::MAX_DIRECTIONS)
            begin
                nbr_mem[base + r.dir]  = r.nbr;
                perm_mem[base + r.dir] = r.perm;
            end
            return;
        end
        // z axis in a problem that is not 3-D: one error entry per request
        if (axis_r >= pnra_pkg::AXIS_Z && dim_r != pnra_pkg::DIM_3)
        begin
            expect_entry(make_entry(r.node, '0, '0, 1'b0, 1'b1, 1'b1));
            error_rows++;
            return;
        end
        if (!r.free)
            return;
        if (r.coord == '0)
        begin
            expect_entry(make_entry(r.node, r.node, pnra_pkg::UNIT_VALUE, 1'b1, 1'b0, 1'b1));
            return;
        end
        if (r.coord >= extent_r)
        begin
            expect_entry(make_entry(r.node, r.node, pnra_pkg::UNIT_VALUE, 1'b0, 1'b0, 1'b1));
            return;
        end
        ndirs = (dim_r == pnra_pkg::DIM_3) ? 6 : 4;
        diag  = '0;
        for (int d = 0; d < ndirs; d++)
        begin
            nb = nbr_mem[base + d];
            if (nb[pnra_pkg::NB_W-1])
                continue;
            far_idx = nb[pnra_pkg::NODE_W-1:0] * pnra_pkg::MAX_DIRECTIONS + FAR_SIDE[d*3 +: 3];
            sum  = perm_mem[base + d] + perm_mem[far_idx];
            diag = diag + sum;
            expect_entry(make_entry(r.node, nb[pnra_pkg::NODE_W-1:0],
                                    -$signed({7'd0, sum}), 1'b0, 1'b0, 1'b0));
        end
        expect_entry(make_entry(r.node, r.node, {4'd0, diag}, 1'b0, 1'b0, 1'b1));
        interior_rows++;
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                accepted_count++;
                assemble_row(cur_req);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req = pending_requests.pop_front();
                    cur_req      <= next_req;
                    cmd          <= next_req.cmd;
                    node         <= next_req.node;
                    direction    <= next_req.dir;
                    neighbor     <= next_req.nbr;
                    permeability <= next_req.perm;
                    is_free      <= next_req.free;
                    coordinate   <= next_req.coord;
                    in_valid     <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern is redrawn each time the 6-bit tick counter wraps; a token bump starts a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
            rx_mode   <= 0;
            rx_tick   <= '0;
        end
        else if (hold_seen != hold_token)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            rx_tick <= rx_tick + 6'd1;
            if (rx_tick == '0)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 99) < 35);
                2:       out_stall <= (rx_tick[1:0] == 2'b11);
                default: out_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_entries.size() == 0)
                report_mismatch("entry with nothing expected, row", 64'(row), '0);
            else
            begin
                want = expected_entries.pop_front();
                entries_checked++;
                if (row !== want.row)
                    report_mismatch("row", 64'(row), 64'(want.row));
                if (column !== want.column)
                    report_mismatch("column", 64'(column), 64'(want.column));
                if (value !== want.value)
                    report_mismatch("value", 64'(value), 64'(want.value));
                if (rhs_increment !== want.rhs_increment)
                    report_mismatch("rhs_increment", 64'(rhs_increment), 64'(want.rhs_increment));
                if (error !== want.error)
                    report_mismatch("error", 64'(error), 64'(want.error));
                if (last !== want.last)
                    report_mismatch("last", 64'(last), 64'(want.last));
            end
        end
    end

    task automatic push_request(input request_t r);
        pending_requests = {pending_requests, r};
        if (!(r.cmd == pnra_pkg::CMD_LOAD && r.dir >= pnra_pkg::MAX_DIRECTIONS))
            queued_count++;
    endtask

    // A present link always gets a loaded reverse entry first, so no process
    // request ever reads an unwritten slot.
    task automatic queue_load(input logic [pnra_pkg::NODE_W-1:0] n,
                              input logic [pnra_pkg::DIRF_W-1:0] d,
                              input logic signed [pnra_pkg::NB_W-1:0] nb,
                              input logic [pnra_pkg::PERM_W-1:0] p);
        request_t    r;
        int unsigned far_idx;
        if (d < pnra_pkg::MAX_DIRECTIONS && !nb[pnra_pkg::NB_W-1])
        begin
            far_idx = nb[pnra_pkg::NODE_W-1:0] * pnra_pkg::MAX_DIRECTIONS + FAR_SIDE[d*3 +: 3];
            if (!loaded_gen[far_idx])
            begin
                r = '{cmd: pnra_pkg::CMD_LOAD, node: nb[pnra_pkg::NODE_W-1:0],
                      dir: FAR_SIDE[d*3 +: 3], nbr: {1'b0, n}, perm: $urandom,
                      free: 1'($urandom_range(0, 1)), coord: $urandom};
                push_request(r);
                loaded_gen[far_idx] = 1'b1;
            end
        end
        r = '{cmd: pnra_pkg::CMD_LOAD, node: n, dir: d, nbr: nb, perm: p,
              free: 1'($urandom_range(0, 1)), coord: $urandom};
        push_request(r);
        if (d < pnra_pkg::MAX_DIRECTIONS)
            loaded_gen[n * pnra_pkg::MAX_DIRECTIONS + d] = 1'b1;
    endtask

    task automatic queue_process(input logic [pnra_pkg::NODE_W-1:0] n, input logic f,
                                 input logic [pnra_pkg::COORD_W-1:0] c);
        request_t r;
        r = '{cmd: pnra_pkg::CMD_PROCESS, node: n, dir: pnra_pkg::DIRF_W'($urandom),
              nbr: pnra_pkg::NB_W'($urandom), perm: $urandom, free: f, coord: c};
        push_request(r);
    endtask

    function automatic bit own_loaded(input logic [pnra_pkg::NODE_W-1:0] n);
        for (int d = 0; d < pnra_pkg::MAX_DIRECTIONS; d++)
            if (!loaded_gen[n * pnra_pkg::MAX_DIRECTIONS + d])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [pnra_pkg::NB_W-1:0] pick_absent();
        if ($urandom_range(0, 1) == 0)
            return NO_NEIGHBOR;
        return pnra_pkg::NB_W'($urandom_range(1024, 2047));
    endfunction

    function automatic logic [pnra_pkg::PERM_W-1:0] pick_perm();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [pnra_pkg::COORD_W-1:0] interior_coord();
        if (extent_r < 2)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 1;
            1:       return extent_r - 1;
            default: return $urandom_range(1, extent_r - 1);
        endcase
    endfunction

    function automatic logic [pnra_pkg::COORD_W-1:0] boundary_coord();
        if ($urandom_range(0, 1) == 0)
            return '0;
        if ($urandom_range(0, 2) == 0)
            return extent_r;
        return $urandom_range(extent_r, 32'hFFFF_FFFF);
    endfunction

    // full row: six loads with random links, then the node itself
    task automatic queue_row_sequence(input logic [pnra_pkg::NODE_W-1:0] n);
        int unsigned                      absent_pct;
        logic signed [pnra_pkg::NB_W-1:0] nb;
        absent_pct = $urandom_range(0, 100);
        for (int d = 0; d < pnra_pkg::MAX_DIRECTIONS; d++)
        begin
            if ($urandom_range(0, 99) < absent_pct)
                nb = pick_absent();
            else
            begin
                case ($urandom_range(0, 9))
                    0:       nb = {1'b0, n};
                    1, 2:    nb = (ready_nodes.size() != 0) ?
                                  {1'b0, ready_nodes[$urandom_range(0, ready_nodes.size() - 1)]} :
                                  pnra_pkg::NB_W'($urandom_range(0, pnra_pkg::MAX_NODES - 1));
                    default: nb = pnra_pkg::NB_W'($urandom_range(0, pnra_pkg::MAX_NODES - 1));
                endcase
            end
            queue_load(n, pnra_pkg::DIRF_W'(d), nb, pick_perm());
        end
        ready_nodes = {ready_nodes, n};
        queue_process(n, 1'b1, interior_coord());
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned                  start;
        int unsigned                  sel;
        logic [pnra_pkg::NODE_W-1:0]  n;
        logic                         f;
        logic [pnra_pkg::COORD_W-1:0] c;
        start = queued_count;
        while (queued_count - start < count)
        begin
            sel = $urandom_range(0, 99);
            n   = pnra_pkg::NODE_W'($urandom_range(0, pnra_pkg::MAX_NODES - 1));
            if (sel < 40 || (sel < 55 && ready_nodes.size() == 0))
                queue_row_sequence(n);
            else if (sel < 55)
                queue_process(ready_nodes[$urandom_range(0, ready_nodes.size() - 1)], 1'b1,
                              interior_coord());
            else if (sel < 67)
                queue_process(n, 1'b1, boundary_coord());
            else if (sel < 77)
                queue_process(n, 1'b0, $urandom);
            else if (sel < 92)
                queue_load(n, pnra_pkg::DIRF_W'($urandom_range(0, 7)),
                           pnra_pkg::NB_W'($urandom), pick_perm());
            else
            begin
                // loose request; kept off interior rows of nodes not fully loaded
                f = 1'($urandom_range(0, 1));
                c = $urandom;
                if (f && c != '0 && c < extent_r && !own_loaded(n)
                    && !(axis_r >= pnra_pkg::AXIS_Z && dim_r != pnra_pkg::DIM_3))
                    f = 1'b0;
                queue_process(n, f, c);
            end
        end
    endtask

    task automatic write_reg(input logic [pnra_pkg::CIDX_W-1:0] idx,
                             input logic [pnra_pkg::CDATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            pnra_pkg::REG_FLOW_AXIS:     axis_r   = data[1:0];
            pnra_pkg::REG_DIMENSION:     dim_r    = data[1:0];
            pnra_pkg::REG_DOMAIN_EXTENT: extent_r = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] axis, input logic [1:0] dim,
                              input logic [pnra_pkg::COORD_W-1:0] extent);
        write_reg(pnra_pkg::REG_FLOW_AXIS, {30'd0, axis});
        write_reg(pnra_pkg::REG_DIMENSION, {30'd0, dim});
        write_reg(pnra_pkg::REG_DOMAIN_EXTENT, extent);
        write_reg(REG_UNUSED, $urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_entries.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows at reset settings: widest sums, absent links, ignored slots
        queue_load(10'd1023, 3'd2, 11'sd0, '1);
        queue_load(10'd1023, 3'd3, 11'sd0, '1);
        queue_load(10'd1023, 3'd0, 11'sd0, '1);
        queue_load(10'd0, 3'd0, 11'sd1023, '1);
        queue_load(10'd0, 3'd1, 11'sd1023, '1);
        queue_load(10'd0, 3'd2, 11'sd1023, '1);
        queue_load(10'd0, 3'd3, NO_NEIGHBOR, '0);
        queue_load(10'd0, 3'd4, -11'sd1024, '1);
        queue_load(10'd0, 3'd5, NO_NEIGHBOR, '0);
        queue_load(10'd0, 3'd6, 11'sd5, '1);
        queue_load(10'd0, 3'd7, NO_NEIGHBOR, '1);
        queue_process(10'd0, 1'b1, 32'd1);
        queue_process(10'd0, 1'b1, 32'd65535);
        queue_process(10'd1023, 1'b0, 32'd1);
        queue_process(10'd1023, 1'b1, 32'd0);
        queue_process(10'd512, 1'b1, 32'd65536);
        queue_process(10'd7, 1'b1, 32'hFFFF_FFFF);
        ready_nodes = {ready_nodes, 10'd0};
        wait_idle();

        set_config(2'd1, 2'd3, 32'hFFFF_FFFF);
        queue_random(20);
        wait_idle();
        queue_random(20);
        wait_idle();

        set_config(2'd0, 2'd2, $urandom_range(2, 32'h00FF_FFFF));
        queue_random(30);
        wait_idle();

        set_config(2'd2, 2'd2, $urandom);
        queue_random(15);
        wait_idle();

        set_config(2'd3, 2'd1, 32'd0);
        queue_random(10);
        wait_idle();

        set_config(2'd3, 2'd3, 32'd0);
        queue_random(15);
        wait_idle();

        set_config(2'd0, 2'd0, 32'd1);
        queue_random(15);
        wait_idle();

        // output held off while requests keep coming
        set_config(2'd2, 2'd3, $urandom_range(32'h0100_0000, 32'hFFFF_FFFF));
        hold_token++;
        queue_random(40);
        wait_idle();

        $display("%0d requests accepted, %0d row entries checked, %0d interior rows, %0d error rows",
                 accepted_count, entries_checked, interior_rows, error_rows);
        $display("8 register settings incl. 2-D error mode, zero and full extent, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
